/* design/mctt_pkg.sv */
package mctt_pkg;

  localparam int unsigned PULSES_PER_QUARTER = 24;

  localparam logic [2:0] OP_CLOCK    = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_CONTINUE = 3'd2;
  localparam logic [2:0] OP_STOP     = 3'd3;
  localparam logic [2:0] OP_SONG_POS = 3'd4;
  localparam logic [2:0] OP_TIMECODE = 3'd5;
  localparam logic [2:0] OP_CHECK    = 3'd6;

  localparam logic CFG_DRIFT_BOUND  = 1'b0;
  localparam logic CFG_LOCK_TIMEOUT = 1'b1;

  localparam logic [19:0] MS_NS       = 20'd1000000;
  localparam logic [17:0] BOUND_SCALE = 18'd256000;
  localparam logic [55:0] TEMPO_NUM   =
    56'(64'd60000000000 * 64'd65536 / 64'(PULSES_PER_QUARTER));

  typedef struct packed {
    logic [2:0]  operation;
    logic [13:0] value;
    logic [63:0] timestamp_ns;
  } in_item_t;

  typedef struct packed {
    logic        locked;
    logic [23:0] tempo_bpm_q8;
    logic [55:0] mean_interval_q8;
    logic [47:0] last_interval_ns;
    logic [56:0] drift_q8;
    logic [47:0] window_span_ns;
    logic [31:0] pulse_total;
    logic [31:0] kind_count;
    logic [13:0] spp_value;
    logic [13:0] mtc_value;
  } out_item_t;

  typedef struct packed {
    logic        is_clock;
    logic        is_count;
    logic        is_stop;
    logic        is_song;
    logic        is_tc;
    logic        is_check;
    logic [2:0]  cnt_idx;
    logic [13:0] value;
    logic [63:0] ts;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [47:0] sat48(input logic [63:0] v);
    return (|v[63:48]) ? '1 : v[47:0];
  endfunction

endpackage

/* design/mctt_front.sv */
module mctt_front (
  input  logic                in_push,
  input  mctt_pkg::in_item_t  in_data,
  input  mctt_pkg::q_status_t q_status,
  output logic                in_full,
  output logic                q_write,
  output mctt_pkg::cmd_t      q_cmd
);

  assign in_full = q_status.full;
  assign q_write = in_push && !q_status.full;

  always_comb begin
    q_cmd          = '0;
    q_cmd.value    = in_data.value;
    q_cmd.ts       = in_data.timestamp_ns;
    q_cmd.cnt_idx  = 3'(in_data.operation - 3'd1);
    case (in_data.operation)
      mctt_pkg::OP_CLOCK:    q_cmd.is_clock = 1'b1;
      mctt_pkg::OP_START:    q_cmd.is_count = 1'b1;
      mctt_pkg::OP_CONTINUE: q_cmd.is_count = 1'b1;
      mctt_pkg::OP_STOP: begin
        q_cmd.is_count = 1'b1;
        q_cmd.is_stop  = 1'b1;
      end
      mctt_pkg::OP_SONG_POS: begin
        q_cmd.is_count = 1'b1;
        q_cmd.is_song  = 1'b1;
      end
      mctt_pkg::OP_TIMECODE: begin
        q_cmd.is_count = 1'b1;
        q_cmd.is_tc    = 1'b1;
      end
      mctt_pkg::OP_CHECK:    q_cmd.is_check = 1'b1;
      default:               q_cmd.cnt_idx  = 3'd0;
    endcase
  end

endmodule

/* design/mctt_queue.sv */
module mctt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_write,
  input  mctt_pkg::cmd_t      q_cmd,
  input  logic                q_pop,
  output mctt_pkg::cmd_t      q_head,
  output mctt_pkg::q_status_t q_status
);

  mctt_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_head         = slot_r[rd_ptr_r];
  assign q_status.empty = (count_r == 2'd0);
  assign q_status.full  = (count_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ q_write;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = 2'(count_r + {1'b0, q_write} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (q_write) begin
      slot_r[wr_ptr_r] <= q_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/mctt_back.sv */
module mctt_back #(
  parameter int unsigned WINDOW_PULSES = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_data,
  input  mctt_pkg::cmd_t      q_head,
  input  mctt_pkg::q_status_t q_status,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output mctt_pkg::out_item_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_EXEC      = 7'b0000010,
    S_CHECK     = 7'b0000100,
    S_DIV_MEAN  = 7'b0001000,
    S_LOCK      = 7'b0010000,
    S_DIV_TEMPO = 7'b0100000,
    S_OUT       = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  mctt_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [19:0]         drift_cfg_r, drift_cfg_nxt;
  logic [15:0]         tmo_cfg_r, tmo_cfg_nxt;
  logic [63:0]         win_start_r, win_start_nxt;
  logic [63:0]         last_pulse_r, last_pulse_nxt;
  logic [47:0]         last_iv_r, last_iv_nxt;
  logic [55:0]         mean_r, mean_nxt;
  logic [47:0]         span_r, span_nxt;
  logic [31:0]         pulses_r, pulses_nxt;
  logic [6:0]          piw_r, piw_nxt;
  logic                lock_r, lock_nxt;
  logic [31:0]         cnt_r [5];
  logic [31:0]         cnt_nxt [5];
  logic [13:0]         song_r, song_nxt;
  logic [13:0]         tc_r, tc_nxt;
  logic [23:0]         tempo_r, tempo_nxt;
  logic [31:0]         kind_r, kind_nxt;
  logic [63:0]         age_r, age_nxt;
  logic [36:0]         thr_r, thr_nxt;
  logic [37:0]         bound_r, bound_nxt;
  logic [55:0]         rem_r, rem_nxt;
  logic [55:0]         quo_r, quo_nxt;
  logic [55:0]         dvd_r, dvd_nxt;
  logic [55:0]         dvsr_r, dvsr_nxt;
  logic [5:0]          dcnt_r, dcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  mctt_pkg::out_item_t out_r, out_nxt;

  logic [63:0] diff_prev, diff_win;
  logic [6:0]  piw_inc;
  logic [56:0] rem_sh;
  logic        rem_ge;
  logic [55:0] quo_step;
  logic [55:0] iv_q8;
  logic [55:0] stray;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    diff_prev = cmd_r.ts - last_pulse_r;
    diff_win  = cmd_r.ts - win_start_r;
    piw_inc   = 7'(piw_r + 7'd1);
    rem_sh    = {rem_r, dvd_r[55]};
    rem_ge    = rem_sh >= {1'b0, dvsr_r};
    quo_step  = {quo_r[54:0], rem_ge};
    iv_q8     = {last_iv_r, 8'd0};
    stray     = (iv_q8 >= quo_r) ? 56'(iv_q8 - quo_r) : 56'(quo_r - iv_q8);
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    drift_cfg_nxt  = drift_cfg_r;
    tmo_cfg_nxt    = tmo_cfg_r;
    win_start_nxt  = win_start_r;
    last_pulse_nxt = last_pulse_r;
    last_iv_nxt    = last_iv_r;
    mean_nxt       = mean_r;
    span_nxt       = span_r;
    pulses_nxt     = pulses_r;
    piw_nxt        = piw_r;
    lock_nxt       = lock_r;
    cnt_nxt        = cnt_r;
    song_nxt       = song_r;
    tc_nxt         = tc_r;
    tempo_nxt      = tempo_r;
    kind_nxt       = kind_r;
    age_nxt        = age_r;
    thr_nxt        = thr_r;
    bound_nxt      = bound_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvd_nxt        = dvd_r;
    dvsr_nxt       = dvsr_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_nxt        = out_r;
    q_pop          = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        mctt_pkg::CFG_DRIFT_BOUND:  drift_cfg_nxt = cfg_data;
        mctt_pkg::CFG_LOCK_TIMEOUT: tmo_cfg_nxt   = cfg_data[15:0];
        default:                    drift_cfg_nxt = drift_cfg_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        kind_nxt  = 32'd0;
        state_nxt = S_OUT;
        thr_nxt   = 37'({1'b0, tmo_cfg_r} + 17'd1) * 37'(mctt_pkg::MS_NS);
        bound_nxt = 38'(drift_cfg_r) * 38'(mctt_pkg::BOUND_SCALE);
        age_nxt   = (cmd_r.ts > last_pulse_r) ? diff_prev : 64'd0;
        if (cmd_r.is_clock) begin
          if (pulses_r == 32'd0 || win_start_r == 64'd0) begin
            win_start_nxt  = cmd_r.ts;
            last_pulse_nxt = cmd_r.ts;
            pulses_nxt     = 32'd1;
            piw_nxt        = 7'd0;
            lock_nxt       = 1'b0;
            kind_nxt       = 32'd1;
          end else begin
            last_pulse_nxt = cmd_r.ts;
            last_iv_nxt    = (last_pulse_r == 64'd0) ? 48'd0 : mctt_pkg::sat48(diff_prev);
            pulses_nxt     = 32'(pulses_r + 32'd1);
            kind_nxt       = 32'(pulses_r + 32'd1);
            piw_nxt        = piw_inc;
            if (piw_inc >= 7'(WINDOW_PULSES)) begin
              span_nxt      = mctt_pkg::sat48(diff_win);
              win_start_nxt = cmd_r.ts;
              piw_nxt       = 7'd0;
              dvd_nxt       = {mctt_pkg::sat48(diff_win), 8'd0};
              dvsr_nxt      = 56'(WINDOW_PULSES);
              rem_nxt       = 56'd0;
              quo_nxt       = 56'd0;
              dcnt_nxt      = 6'd0;
              state_nxt     = S_DIV_MEAN;
            end
          end
        end else if (cmd_r.is_count) begin
          cnt_nxt[cmd_r.cnt_idx] = 32'(cnt_r[cmd_r.cnt_idx] + 32'd1);
          kind_nxt               = 32'(cnt_r[cmd_r.cnt_idx] + 32'd1);
          if (cmd_r.is_stop) begin
            lock_nxt      = 1'b0;
            win_start_nxt = 64'd0;
            piw_nxt       = 7'd0;
          end
          if (cmd_r.is_song) begin
            song_nxt = cmd_r.value;
          end
          if (cmd_r.is_tc) begin
            tc_nxt = cmd_r.value;
          end
        end else if (cmd_r.is_check && lock_r) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (age_r >= 64'(thr_r)) begin
          lock_nxt      = 1'b0;
          win_start_nxt = 64'd0;
          piw_nxt       = 7'd0;
        end
        state_nxt = S_OUT;
      end
      S_DIV_MEAN, S_DIV_TEMPO: begin
        rem_nxt  = rem_ge ? 56'(rem_sh - {1'b0, dvsr_r}) : rem_sh[55:0];
        quo_nxt  = quo_step;
        dvd_nxt  = {dvd_r[54:0], 1'b0};
        dcnt_nxt = 6'(dcnt_r + 6'd1);
        if (dcnt_r == 6'd55) begin
          if (state_r == S_DIV_MEAN) begin
            state_nxt = S_LOCK;
          end else begin
            tempo_nxt = (|quo_step[55:24]) ? '1 : quo_step[23:0];
            state_nxt = S_OUT;
          end
        end
      end
      S_LOCK: begin
        mean_nxt = quo_r;
        lock_nxt = stray <= 56'(bound_r);
        if (quo_r != 56'd0) begin
          dvd_nxt   = mctt_pkg::TEMPO_NUM;
          dvsr_nxt  = quo_r;
          rem_nxt   = 56'd0;
          quo_nxt   = 56'd0;
          dcnt_nxt  = 6'd0;
          state_nxt = S_DIV_TEMPO;
        end else begin
          tempo_nxt = 24'd0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_nxt.locked           = lock_r;
          out_nxt.tempo_bpm_q8     = (lock_r && mean_r != 56'd0) ? tempo_r : 24'd0;
          out_nxt.mean_interval_q8 = mean_r;
          out_nxt.last_interval_ns = last_iv_r;
          out_nxt.drift_q8         = (mean_r != 56'd0) ?
                                     57'({1'b0, iv_q8} - {1'b0, mean_r}) : 57'd0;
          out_nxt.window_span_ns   = span_r;
          out_nxt.pulse_total      = pulses_r;
          out_nxt.kind_count       = kind_r;
          out_nxt.spp_value        = song_r;
          out_nxt.mtc_value        = tc_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    tempo_r <= tempo_nxt;
    kind_r  <= kind_nxt;
    age_r   <= age_nxt;
    thr_r   <= thr_nxt;
    bound_r <= bound_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvd_r   <= dvd_nxt;
    dvsr_r  <= dvsr_nxt;
    dcnt_r  <= dcnt_nxt;
    out_r   <= out_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      drift_cfg_r  <= 20'd1000;
      tmo_cfg_r    <= 16'd500;
      win_start_r  <= 64'd0;
      last_pulse_r <= 64'd0;
      last_iv_r    <= 48'd0;
      mean_r       <= 56'd0;
      span_r       <= 48'd0;
      pulses_r     <= 32'd0;
      piw_r        <= 7'd0;
      lock_r       <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        cnt_r[i] <= 32'd0;
      end
      song_r       <= 14'd0;
      tc_r         <= 14'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      drift_cfg_r  <= drift_cfg_nxt;
      tmo_cfg_r    <= tmo_cfg_nxt;
      win_start_r  <= win_start_nxt;
      last_pulse_r <= last_pulse_nxt;
      last_iv_r    <= last_iv_nxt;
      mean_r       <= mean_nxt;
      span_r       <= span_nxt;
      pulses_r     <= pulses_nxt;
      piw_r        <= piw_nxt;
      lock_r       <= lock_nxt;
      cnt_r        <= cnt_nxt;
      song_r       <= song_nxt;
      tc_r         <= tc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

/* design/midi_clock_tempo_tracker_top.sv */
// Channel   Handshake            Payload
// input     in_push / in_full    in_data  (mctt_pkg::in_item_t)
// result    out_pop / out_empty  out_data (mctt_pkg::out_item_t)
// config    cfg_we               cfg_index, cfg_data
//
// An accepted item goes from the queue via S_IDLE, S_EXEC and S_OUT into the
// result register, via S_CHECK too for a time check while locked; a clock
// pulse closing a window also passes S_DIV_MEAN, S_LOCK and, for a non-zero
// mean, S_DIV_TEMPO; mean and tempo share a one-bit-per-cycle divider.
// Reset is synchronous; the block is ready in the cycle after rst_n rises.
// A two-item queue parts the input from the execution side; a full result
// register stalls execution, not the input, until that queue fills.
module midi_clock_tempo_tracker_top #(
  parameter int unsigned WINDOW_PULSES = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  mctt_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output mctt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_data
);

  mctt_pkg::q_status_t q_status;
  mctt_pkg::cmd_t      q_cmd;
  mctt_pkg::cmd_t      q_head;
  logic                q_write;
  logic                q_pop;

  mctt_front u_front (
    .in_push  (in_push),
    .in_data  (in_data),
    .q_status (q_status),
    .in_full  (in_full),
    .q_write  (q_write),
    .q_cmd    (q_cmd)
  );

  mctt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_write  (q_write),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .q_head   (q_head),
    .q_status (q_status)
  );

  mctt_back #(
    .WINDOW_PULSES (WINDOW_PULSES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_head    (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

/* design/mctt_checker.sv */
module mctt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input mctt_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");

  a_tempo_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.locked) |-> (out_data.tempo_bpm_q8 == 24'd0))
    else $error("tempo reported while unlocked");

  a_drift_no_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.mean_interval_q8 == 56'd0) |-> (out_data.drift_q8 == 57'd0))
    else $error("drift reported without a mean");

endmodule

bind midi_clock_tempo_tracker_top mctt_checker u_mctt_checker (.*);

/* verif/midi_clock_tempo_tracker_checker.sv */
`timescale 1ns / 100ps

module midi_clock_tempo_tracker_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  mctt_pkg::in_item_t  in_data,
  input  logic                out_empty,
  input  logic                out_pop,
  input  mctt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  localparam int unsigned WINDOW = 24;

  logic [19:0] drift_bound;
  logic [15:0] lock_timeout;
  logic [63:0] win_start;
  logic [63:0] last_pulse;
  logic [47:0] last_iv;
  logic [55:0] mean_q8;
  logic [47:0] span;
  logic [31:0] pulses;
  logic [6:0]  win_count;
  logic        locked;
  logic [31:0] counters [5];
  logic [13:0] song_pos;
  logic [13:0] tcode;

  mctt_pkg::out_item_t tracker_results [$];

  function automatic logic [47:0] clamp48(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
  endfunction

  task automatic unlock();
    locked = 1'b0;
    win_start = '0;
    win_count = '0;
  endtask

  task automatic track_tempo(input mctt_pkg::in_item_t it);
    mctt_pkg::out_item_t r;
    logic [63:0] t, sp, mean, iv, stray, age, tempo;
    logic [31:0] kind;
    int k;
    t = it.timestamp_ns;
    kind = '0;
    case (it.operation)
      mctt_pkg::OP_CLOCK: begin
        if (pulses == 0 || win_start == 0) begin
          win_start = t;
          last_pulse = t;
          pulses = 1;
          win_count = '0;
          locked = 1'b0;
        end else begin
          last_iv = (last_pulse == 0) ? 48'd0 : clamp48(t - last_pulse);
          last_pulse = t;
          win_count = win_count + 7'd1;
          pulses = pulses + 32'd1;
          if (win_count >= WINDOW) begin
            sp = 64'(clamp48(t - win_start));
            mean = (sp << 8) / 64'(win_count);
            iv = 64'(last_iv) << 8;
            stray = (iv >= mean) ? iv - mean : mean - iv;
            mean_q8 = mean[55:0];
            span = sp[47:0];
            win_start = t;
            win_count = '0;
            locked = stray <= 64'(drift_bound) * 64'd256000;
          end
        end
        kind = pulses;
      end
      mctt_pkg::OP_START, mctt_pkg::OP_CONTINUE, mctt_pkg::OP_STOP,
      mctt_pkg::OP_SONG_POS, mctt_pkg::OP_TIMECODE: begin
        k = int'(it.operation) - 1;
        counters[k] = counters[k] + 32'd1;
        kind = counters[k];
        if (it.operation == mctt_pkg::OP_STOP) unlock();
        else if (it.operation == mctt_pkg::OP_SONG_POS) song_pos = it.value;
        else if (it.operation == mctt_pkg::OP_TIMECODE) tcode = it.value;
      end
      mctt_pkg::OP_CHECK: begin
        if (locked) begin
          age = (t > last_pulse) ? (t - last_pulse) / 64'd1000000 : 64'd0;
          if (age > 64'(lock_timeout)) unlock();
        end
      end
      default: ;
    endcase
    tempo = '0;
    if (locked && mean_q8 != 0) begin
      tempo = (64'd60000000000 * 64'd65536 / 64'd24) / 64'(mean_q8);
      if (tempo > 64'hFF_FFFF) tempo = 64'hFF_FFFF;
    end
    r.locked = locked;
    r.tempo_bpm_q8 = tempo[23:0];
    r.mean_interval_q8 = mean_q8;
    r.last_interval_ns = last_iv;
    r.drift_q8 = (mean_q8 != 0) ? 57'((64'(last_iv) << 8) - 64'(mean_q8)) : 57'd0;
    r.window_span_ns = span;
    r.pulse_total = pulses;
    r.kind_count = kind;
    r.spp_value = song_pos;
    r.mtc_value = tcode;
    tracker_results.push_back(r);
  endtask

  task automatic cmp(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, actual %0h", name, e, a);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    mctt_pkg::out_item_t e;
    if (!rst_n) begin
      drift_bound = 20'd1000;
      lock_timeout = 16'd500;
      win_start = '0; last_pulse = '0; last_iv = '0; mean_q8 = '0; span = '0;
      pulses = '0; win_count = '0; locked = 1'b0;
      for (int i = 0; i < 5; i++) counters[i] = '0;
      song_pos = '0; tcode = '0;
      tracker_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (tracker_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          e = tracker_results.pop_front();
          cmp("locked", 64'(e.locked), 64'(out_data.locked));
          cmp("tempo_bpm_q8", 64'(e.tempo_bpm_q8), 64'(out_data.tempo_bpm_q8));
          cmp("mean_interval_q8", 64'(e.mean_interval_q8), 64'(out_data.mean_interval_q8));
          cmp("last_interval_ns", 64'(e.last_interval_ns), 64'(out_data.last_interval_ns));
          cmp("drift_q8", 64'(e.drift_q8), 64'(out_data.drift_q8));
          cmp("window_span_ns", 64'(e.window_span_ns), 64'(out_data.window_span_ns));
          cmp("pulse_total", 64'(e.pulse_total), 64'(out_data.pulse_total));
          cmp("kind_count", 64'(e.kind_count), 64'(out_data.kind_count));
          cmp("spp_value", 64'(e.spp_value), 64'(out_data.spp_value));
          cmp("mtc_value", 64'(e.mtc_value), 64'(out_data.mtc_value));
        end
      end
      if (in_push && !in_full) track_tempo(in_data);
      if (cfg_we) begin
        if (cfg_index == mctt_pkg::CFG_DRIFT_BOUND) drift_bound = cfg_data;
        else lock_timeout = cfg_data[15:0];
      end
    end
    pending = tracker_results.size();
  end
endmodule

/* verif/midi_clock_tempo_tracker_top_tb.sv */
`timescale 1ns / 100ps

module midi_clock_tempo_tracker_top_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  mctt_pkg::in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  mctt_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [19:0] cfg_data = '0;
  int fail_count;
  int pending;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  logic [63:0] now_ns = 64'd1000;

  always #6 clk = ~clk;

  midi_clock_tempo_tracker_top DUT (.*);

  midi_clock_tempo_tracker_checker u_checker (.*);

  task automatic send(input logic [2:0] op, input logic [13:0] val, input logic [63:0] ts);
    while (!calm && $urandom_range(99) < 34) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{operation: op, value: val, timestamp_ns: ts};
    do @(posedge clk); while (in_full);
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic pulse_train(input int n, input logic [63:0] period, input logic [63:0] jitter);
    for (int i = 0; i < n; i++) begin
      now_ns = now_ns + period + (jitter != 0 ? 64'($urandom_range(32'(jitter))) : 64'd0);
      send(mctt_pkg::OP_CLOCK, 14'($urandom), now_ns);
    end
  endtask

  task automatic random_item();
    logic [2:0] op;
    logic [63:0] ts;
    op = 3'($urandom_range(7));
    case ($urandom_range(9))
      0: ts = {$urandom, $urandom};
      1: ts = 64'd0;
      2: ts = now_ns - 64'($urandom_range(1000000));
      default: begin
        now_ns = now_ns + 64'($urandom_range(30000000));
        ts = now_ns;
      end
    endcase
    send(op, 14'($urandom), ts);
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_pop <= 1'b0;
    else out_pop <= calm || ($urandom_range(99) >= 34);
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(mctt_pkg::CFG_DRIFT_BOUND, 20'd1000);
    write_reg(mctt_pkg::CFG_LOCK_TIMEOUT, 16'd500);

    send(mctt_pkg::OP_CHECK, 14'd0, 64'd5);
    send(mctt_pkg::OP_CLOCK, 14'd0, 64'd0);
    send(mctt_pkg::OP_CLOCK, 14'h3FFF, 64'd0);
    send(mctt_pkg::OP_START, 14'h3FFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(mctt_pkg::OP_CONTINUE, 14'd0, 64'd1);
    send(mctt_pkg::OP_SONG_POS, 14'h3FFF, 64'd2);
    send(mctt_pkg::OP_TIMECODE, 14'h2AAA, 64'd3);
    send(3'd7, 14'h1555, 64'd4);
    pulse_train(25, 64'd20833333, 64'd0);
    send(mctt_pkg::OP_CHECK, 14'd0, now_ns + 64'd1000);
    send(mctt_pkg::OP_CHECK, 14'd0, now_ns + 64'd900000000);
    pulse_train(25, 64'd20833333, 64'd0);
    send(mctt_pkg::OP_STOP, 14'd0, now_ns);
    pulse_train(26, 64'h1_0000_0000_0000, 64'd0);
    drain();

    calm = 1'b1;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++) random_item();
    join
    calm = 1'b0;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(mctt_pkg::CFG_DRIFT_BOUND, 20'd0);
          write_reg(mctt_pkg::CFG_LOCK_TIMEOUT, 16'd1);
        end
        1: begin
          write_reg(mctt_pkg::CFG_DRIFT_BOUND, 20'd1000000);
          write_reg(mctt_pkg::CFG_LOCK_TIMEOUT, 16'd60000);
        end
        2: begin
          write_reg(mctt_pkg::CFG_DRIFT_BOUND, 20'hFFFFF);
          write_reg(mctt_pkg::CFG_LOCK_TIMEOUT, 16'd0);
        end
        3: begin
          write_reg(mctt_pkg::CFG_DRIFT_BOUND, 20'($urandom));
          write_reg(mctt_pkg::CFG_LOCK_TIMEOUT, 16'hFFFF);
        end
        default: begin
          write_reg(mctt_pkg::CFG_DRIFT_BOUND, 20'($urandom_range(5000)));
          write_reg(mctt_pkg::CFG_LOCK_TIMEOUT, 16'($urandom_range(1000, 1)));
        end
      endcase
      calm = (phase == 2);
      for (int n = 0; n < 300; ) begin
        if ($urandom_range(9) < 7) begin
          pulse_train(24, 64'($urandom_range(40000000, 1000)), 64'($urandom_range(3000000)));
          send(mctt_pkg::OP_CHECK, 14'd0, now_ns + 64'($urandom_range(2000000000)));
          n += 25;
        end else begin
          random_item();
          n++;
        end
      end
      calm = 1'b0;
      drain();
    end

    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
